// ----- rtl/u16550_pkg.sv -----
// shared types, constants and field codes for the 16550 register block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package u16550_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;

  localparam int IN_W  = 32;
  localparam int OUT_W = 40;

  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_RX      = 3'd2,
    OP_MODEM   = 3'd3,
    OP_TIMEOUT = 3'd4
  } op_e;

  localparam logic [2:0] ADDR_RBR = 3'd0;
  localparam logic [2:0] ADDR_IER = 3'd1;
  localparam logic [2:0] ADDR_IIR = 3'd2;
  localparam logic [2:0] ADDR_LCR = 3'd3;
  localparam logic [2:0] ADDR_MCR = 3'd4;
  localparam logic [2:0] ADDR_LSR = 3'd5;
  localparam logic [2:0] ADDR_MSR = 3'd6;

  localparam logic [3:0] IID_NONE    = 4'h1;
  localparam logic [3:0] IID_LINE    = 4'h6;
  localparam logic [3:0] IID_TIMEOUT = 4'hC;
  localparam logic [3:0] IID_DATA    = 4'h4;
  localparam logic [3:0] IID_THRE    = 4'h2;
  localparam logic [3:0] IID_MODEM   = 4'h0;

  localparam logic [7:0] FCR_MASK    = 8'hC9;
  localparam logic [7:0] LSR_INT_ANY = 8'h1E;
  localparam logic [7:0] LSR_DR      = 8'h01;
  localparam logic [7:0] LSR_OE      = 8'h02;
  localparam logic [7:0] LSR_BI      = 8'h10;
  localparam logic [7:0] LSR_THRE    = 8'h20;
  localparam logic [7:0] LSR_TEMT    = 8'h40;

  typedef struct packed {
    logic [3:0] modem_lines;
    logic [7:0] rx_byte;
    logic [7:0] write_data;
    logic [2:0] address;
    logic [2:0] operation;
  } in_word_t;

  typedef struct packed {
    logic [15:0] divisor;
    logic        break_out;
    logic [3:0]  modem_out;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        interrupt;
    logic [7:0]  read_data;
  } out_word_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [7:0] wdata;
  } fifo_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [7:0]       rdata;
  } fifo_stat_t;

endpackage

// ----- rtl/u16550_rx_fifo.sv -----
// receive fifo: flip-flop storage with head pointer and fill count
// depends on u16550_pkg
`timescale 1ns / 1ps

module u16550_rx_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  u16550_pkg::fifo_ctrl_t ctrl_i,
  output u16550_pkg::fifo_stat_t stat_o
);
  import u16550_pkg::*;

  logic [7:0]       store_q [FIFO_DEPTH];
  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] tail_sum;
  logic [PTR_W-1:0] tail;

  always_comb begin
    tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
    if (tail_sum >= SUM_W'(FIFO_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(FIFO_DEPTH);
    end
    tail = tail_sum[PTR_W-1:0];
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctrl_i.clear) begin
      head_d  = '0;
      count_d = '0;
    end else if (ctrl_i.pop) begin
      head_d  = (head_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end else if (ctrl_i.push) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !ctrl_i.clear && !ctrl_i.pop) begin
      store_q[tail] <= ctrl_i.wdata;
    end
  end

  assign stat_o.count = count_q;
  assign stat_o.rdata = store_q[head_q];

endmodule

// ----- rtl/u16550_core.sv -----
// register file and interrupt logic; one word updates the state per cycle while step_i is high
// depends on u16550_pkg only; it talks to u16550_rx_fifo through the fifo structs
`timescale 1ns / 1ps

module u16550_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  u16550_pkg::in_word_t   word_i,
  input  u16550_pkg::fifo_stat_t fifo_i,
  output u16550_pkg::fifo_ctrl_t fifo_o,
  output u16550_pkg::out_word_t  result_o
);
  import u16550_pkg::*;

  logic [7:0]  rbr_q, rbr_d;
  logic [3:0]  ier_q, ier_d;
  logic [7:0]  iir_q, iir_d;
  logic [7:0]  lcr_q, lcr_d;
  logic [4:0]  mcr_q, mcr_d;
  logic [7:0]  lsr_q, lsr_d;
  logic [7:0]  msr_q, msr_d;
  logic [7:0]  fcr_q, fcr_d;
  logic [3:0]  trig_q, trig_d;
  logic [15:0] dl_q, dl_d;
  logic [7:0]  scr_q, scr_d;
  logic        thre_q, thre_d;
  logic        tout_q, tout_d;

  logic             refresh, rx_en, txv;
  logic [7:0]       rx_val, rd, fv, lv;
  logic [3:0]       changed, delta, iid;
  logic [CNT_W-1:0] cnt_new;
  logic             dlab;

  always_comb begin
    rbr_d = rbr_q; ier_d = ier_q; iir_d = iir_q; lcr_d = lcr_q; mcr_d = mcr_q;
    lsr_d = lsr_q; msr_d = msr_q; fcr_d = fcr_q; trig_d = trig_q; dl_d = dl_q;
    scr_d = scr_q; thre_d = thre_q; tout_d = tout_q;
    refresh = 1'b0;
    rx_en   = 1'b0;
    rx_val  = word_i.rx_byte;
    txv     = 1'b0;
    rd      = '0;
    fv      = '0;
    lv      = '0;
    changed = '0;
    delta   = '0;
    fifo_o  = '0;
    fifo_o.wdata = rx_val;
    cnt_new = fifo_i.count;
    dlab    = lcr_q[7];

    if (step_i) begin
      unique case (word_i.operation)
        OP_READ: begin
          unique case (word_i.address)
            ADDR_RBR: begin
              if (dlab) begin
                rd = dl_q[7:0];
              end else if (fcr_q[0]) begin
                if (fifo_i.count != '0) begin
                  rd         = fifo_i.rdata;
                  fifo_o.pop = 1'b1;
                  cnt_new    = fifo_i.count - 1'b1;
                end
                if (cnt_new == '0) begin
                  lsr_d = lsr_d & ~(LSR_DR | LSR_BI);
                end
                tout_d  = 1'b0;
                refresh = 1'b1;
              end else begin
                rd      = rbr_q;
                lsr_d   = lsr_d & ~(LSR_DR | LSR_BI);
                refresh = 1'b1;
              end
            end
            ADDR_IER: rd = dlab ? dl_q[15:8] : {4'b0, ier_q};
            ADDR_IIR: begin
              rd = iir_q;
              if (iir_q[2:1] == 2'b01) begin
                thre_d  = 1'b0;
                refresh = 1'b1;
              end
            end
            ADDR_LCR: rd = lcr_q;
            ADDR_MCR: rd = {3'b0, mcr_q};
            ADDR_LSR: begin
              rd = lsr_q;
              if ((lsr_q & (LSR_BI | LSR_OE)) != '0) begin
                lsr_d   = lsr_q & ~(LSR_BI | LSR_OE);
                refresh = 1'b1;
              end
            end
            ADDR_MSR: begin
              if (mcr_q[4]) begin
                // loopback maps outputs onto the status inputs
                rd = {mcr_q[3], mcr_q[2], mcr_q[0], mcr_q[1], 4'b0};
              end else begin
                rd = msr_q;
                if (msr_q[3:0] != '0) begin
                  msr_d   = {msr_q[7:4], 4'b0};
                  refresh = 1'b1;
                end
              end
            end
            default: rd = scr_q;
          endcase
        end
        OP_WRITE: begin
          unique case (word_i.address)
            ADDR_RBR: begin
              if (dlab) begin
                dl_d[7:0] = word_i.write_data;
              end else begin
                lsr_d   = lsr_d | LSR_THRE | LSR_TEMT;
                thre_d  = 1'b1;
                refresh = 1'b1;
                if (mcr_q[4]) begin
                  rx_en  = 1'b1;
                  rx_val = word_i.write_data;
                end else begin
                  txv = 1'b1;
                end
              end
            end
            ADDR_IER: begin
              if (dlab) begin
                dl_d[15:8] = word_i.write_data;
              end else begin
                changed = ier_q ^ word_i.write_data[3:0];
                ier_d   = word_i.write_data[3:0];
                if (changed[1]) begin
                  thre_d = ier_d[1] && lsr_q[5];
                end
                refresh = (changed != '0);
              end
            end
            ADDR_IIR: begin
              fv = word_i.write_data;
              if (fv[0] != fcr_q[0]) begin
                fv = fv | 8'h06;
              end
              if (fv[1]) begin
                lsr_d        = lsr_d & ~(LSR_DR | LSR_BI);
                tout_d       = 1'b0;
                fifo_o.clear = 1'b1;
                cnt_new      = '0;
              end
              if (fv[2]) begin
                lsr_d  = lsr_d | LSR_THRE;
                thre_d = 1'b1;
              end
              fcr_d = fv & FCR_MASK;
              if (fcr_d[0]) begin
                iir_d[7:6] = 2'b11;
                unique case (fcr_d[7:6])
                  2'b00:   trig_d = 4'd1;
                  2'b01:   trig_d = 4'd4;
                  2'b10:   trig_d = 4'd8;
                  default: trig_d = 4'd14;
                endcase
              end else begin
                iir_d[7:6] = 2'b00;
              end
              refresh = 1'b1;
            end
            ADDR_LCR: lcr_d = word_i.write_data;
            ADDR_MCR: mcr_d = word_i.write_data[4:0];
            ADDR_LSR, ADDR_MSR: ;
            default:  scr_d = word_i.write_data;
          endcase
        end
        OP_RX: rx_en = 1'b1;
        OP_MODEM: begin
          lv    = {word_i.modem_lines[2], word_i.modem_lines[3],
                   word_i.modem_lines[1], word_i.modem_lines[0], 4'b0};
          delta = msr_q[7:4] ^ lv[7:4];
          // ring indicator delta only on a falling edge
          if (!(msr_q[6] && !lv[6])) begin
            delta[2] = 1'b0;
          end
          msr_d   = {lv[7:4], msr_q[3:0] | delta};
          refresh = (msr_d != msr_q);
        end
        OP_TIMEOUT: begin
          if (fifo_i.count != '0) begin
            tout_d  = 1'b1;
            refresh = 1'b1;
          end
        end
        default: ;
      endcase

      if (rx_en) begin
        fifo_o.wdata = rx_val;
        if (fcr_q[0]) begin
          if (32'(fifo_i.count) < FIFO_DEPTH) begin
            fifo_o.push = 1'b1;
            cnt_new     = fifo_i.count + 1'b1;
          end else begin
            lsr_d = lsr_d | LSR_OE;
          end
        end else begin
          if (lsr_d[0]) begin
            lsr_d = lsr_d | LSR_OE;
          end
          rbr_d = rx_val;
        end
        lsr_d   = lsr_d | LSR_DR;
        refresh = 1'b1;
      end
    end

    // interrupt priority on the updated state
    if (ier_d[2] && ((lsr_d & LSR_INT_ANY) != '0)) begin
      iid = IID_LINE;
    end else if (ier_d[0] && tout_d) begin
      iid = IID_TIMEOUT;
    end else if (ier_d[0] && lsr_d[0] &&
                 (!fcr_d[0] || 32'(cnt_new) >= 32'(trig_d))) begin
      iid = IID_DATA;
    end else if (ier_d[1] && thre_d) begin
      iid = IID_THRE;
    end else if (ier_d[3] && (msr_d[3:0] != '0)) begin
      iid = IID_MODEM;
    end else begin
      iid = IID_NONE;
    end
    if (refresh) begin
      iir_d[3:0] = iid;
    end

    result_o.read_data = rd;
    result_o.interrupt = !iir_d[0];
    result_o.tx_valid  = txv;
    result_o.tx_byte   = txv ? word_i.write_data : 8'h00;
    result_o.modem_out = mcr_d[4] ? 4'h0 : mcr_d[3:0];
    result_o.break_out = lcr_d[6];
    result_o.divisor   = dl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rbr_q <= '0; ier_q <= '0; iir_q <= 8'h01; lcr_q <= '0; mcr_q <= 5'h08;
      lsr_q <= 8'h60; msr_q <= 8'hB0; fcr_q <= '0; trig_q <= 4'd1;
      dl_q <= 16'd12; scr_q <= '0; thre_q <= 1'b0; tout_q <= 1'b0;
    end else begin
      rbr_q <= rbr_d; ier_q <= ier_d; iir_q <= iir_d; lcr_q <= lcr_d;
      mcr_q <= mcr_d; lsr_q <= lsr_d; msr_q <= msr_d; fcr_q <= fcr_d;
      trig_q <= trig_d; dl_q <= dl_d; scr_q <= scr_d; thre_q <= thre_d;
      tout_q <= tout_d;
    end
  end

  a_fcr_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fcr_q & ~FCR_MASK) == '0) else $error("fcr holds unused bits");
  a_iir_fifo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iir_q[7:6] == {fcr_q[0], fcr_q[0]}) else $error("iir fifo bits disagree");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fifo_i.count) <= FIFO_DEPTH) else $error("rx fill count past depth");
  a_thr_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.tx_valid |-> !mcr_q[4]) else $error("tx byte sent in loopback");

endmodule

// ----- rtl/uart_16550_register_block.sv -----
// 16550a register block top level: input stage, core, rx fifo, result stage
// depends on u16550_pkg, u16550_rx_fifo and u16550_core
// a word passes the input stage and then the result stage before it is seen on the master side
// throughput: one word per cycle while the master side takes results, the state update is a single pass per word
// while a result waits to be taken, the input stage takes a new word only if it holds none
// reset: asynchronous active low, core registers return to their 16550 values; payload registers are not reset
`timescale 1ns / 1ps

module uart_16550_register_block (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // operation, address, write_data, rx_byte, modem_lines, zero pad
  input  logic [u16550_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // read_data, interrupt, tx_valid, tx_byte, modem_out, break_out, divisor
  output logic [u16550_pkg::OUT_W-1:0]  m_axis_tdata
);
  import u16550_pkg::*;

  // input stage holds one word until the core can take it
  logic       in_valid_q;
  in_word_t   in_word_q;
  // result stage
  logic       out_valid_q;
  out_word_t  out_word_q;

  logic       advance;
  fifo_ctrl_t fifo_ctrl;
  fifo_stat_t fifo_stat;
  out_word_t  result;

  // the core steps whenever a word is held and the result stage is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_word_q <= in_word_t'(s_axis_tdata[$bits(in_word_t)-1:0]);
    end
    if (advance) begin
      out_word_q <= result;
    end
  end

  u16550_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .word_i   (in_word_q),
    .fifo_i   (fifo_stat),
    .fifo_o   (fifo_ctrl),
    .result_o (result)
  );

  u16550_rx_fifo u_rx_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (fifo_ctrl),
    .stat_o (fifo_stat)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_W - $bits(out_word_t))'(0), out_word_q};

endmodule
